// ===== hdl/curl_p_sponge_hash_unit_defines.svh =====
// Assertion macros for the Curl-P sponge hash unit.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef CURL_P_SPONGE_HASH_UNIT_DEFINES_SVH
`define CURL_P_SPONGE_HASH_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CURLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CURLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/curlp_pkg.sv =====
// Shared types, constants and the trit substitution function of the Curl-P unit.
// No dependencies.
package curlp_pkg;

  localparam int unsigned StateTritsDef = 729;
  localparam int unsigned RateTritsDef  = 243;
  localparam int unsigned PosW          = 8;
  localparam int unsigned RoundW        = 8;
  localparam int unsigned QueueDepth    = 2;
  localparam logic [RoundW-1:0] RoundCountRst = 8'd81;

  localparam logic [1:0] TritZero = 2'b00;
  localparam logic [1:0] TritPos  = 2'b01;
  localparam logic [1:0] TritBad  = 2'b10;
  localparam logic [1:0] TritNeg  = 2'b11;

  typedef enum logic [1:0] {
    ModeClear   = 2'd0,
    ModeAbsorb  = 2'd1,
    ModeSqueeze = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [1:0] trit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } core_stat_t;

  function automatic logic [1:0] trit_sbox(logic [1:0] a, logic [1:0] b);
    logic [1:0] r;
    case ({b, a})
      {TritNeg, TritNeg}:   r = TritPos;
      {TritNeg, TritZero}:  r = TritZero;
      {TritNeg, TritPos}:   r = TritNeg;
      {TritZero, TritNeg}:  r = TritPos;
      {TritZero, TritZero}: r = TritNeg;
      {TritZero, TritPos}:  r = TritZero;
      {TritPos, TritNeg}:   r = TritNeg;
      {TritPos, TritZero}:  r = TritPos;
      {TritPos, TritPos}:   r = TritZero;
      default:              r = TritZero;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/curlp_front.sv =====
// Front end: takes input beats, drops unused modes, normalizes the trit.
// Depends on curlp_pkg.
module curlp_front import curlp_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic signed [1:0] trit_in_i,
  input  logic              last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  logic keep;

  assign in_stall_o = q_full_i;

  always_comb begin
    case (mode_i)
      ModeClear, ModeAbsorb, ModeSqueeze: keep = 1'b1;
      default:                            keep = 1'b0;
    endcase
  end

  assign push_o = in_valid_i && !q_full_i && keep;

  always_comb begin
    cmd_o.mode = mode_e'(mode_i);
    // saturate minus two to minus one
    cmd_o.trit = trit_in_i[1] ? TritNeg : {1'b0, trit_in_i[0]};
    cmd_o.last = last_i && (mode_i != ModeClear);
  end

endmodule

// ===== hdl/curlp_fifo.sv =====
// Short command queue between front end and sponge core.
// Depends on curlp_pkg.
module curlp_fifo import curlp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/curlp_core.sv =====
// Sponge core: trit state, rate position, round sequencer and result register.
// Depends on curlp_pkg.
module curlp_core import curlp_pkg::*; #(
  parameter int unsigned STATE_TRITS = StateTritsDef,
  parameter int unsigned RATE_TRITS  = RateTritsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  input  logic [RoundW-1:0] round_count_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [1:0] trit_out_o,
  output core_stat_t        stat_o
);

  localparam int unsigned Half  = STATE_TRITS / 2;
  localparam int unsigned ReadN = (RATE_TRITS < STATE_TRITS) ? RATE_TRITS : STATE_TRITS;
  localparam logic [PosW:0] RateLim = (PosW + 1)'(RATE_TRITS);

  logic [1:0]        st_q [STATE_TRITS];
  logic [PosW-1:0]   pos_q, pos_d;
  logic [RoundW-1:0] rounds_q, rounds_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        trit_q, trit_d;

  logic            busy, out_free, pop, end_blk;
  logic [PosW:0]   pos_inc;
  logic [1:0]      sq_trit;

  assign busy     = (rounds_q != '0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = cmd_valid_i && !busy && ((cmd_i.mode != ModeSqueeze) || out_free);
  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign end_blk  = cmd_i.last || (pos_inc >= RateLim);

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign trit_out_o  = trit_q;
  assign stat_o      = '{busy: busy, pop: pop};

  for (genvar i = 0; i < STATE_TRITS; i++) begin : g_trit
    localparam int unsigned PA = (i * Half) % STATE_TRITS;
    localparam int unsigned PB = ((i + 1) * Half) % STATE_TRITS;
    logic       wr_hit;
    logic [1:0] st_d;

    if (i < RATE_TRITS) begin : g_rate
      assign wr_hit = (pos_q == PosW'(i));
    end else begin : g_cap
      assign wr_hit = 1'b0;
    end

    always_comb begin
      st_d = st_q[i];
      if (busy) begin
        st_d = trit_sbox(st_q[PA], st_q[PB]);
      end else if (pop && (cmd_i.mode == ModeClear)) begin
        st_d = TritZero;
      end else if (pop && (cmd_i.mode == ModeAbsorb) && wr_hit) begin
        st_d = cmd_i.trit;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i] <= TritZero;
      end else begin
        st_q[i] <= st_d;
      end
    end
  end

  always_comb begin
    sq_trit = TritZero;
    for (int j = 0; j < ReadN; j++) begin
      if (pos_q == PosW'(j)) begin
        sq_trit = sq_trit | st_q[j];
      end
    end
  end

  always_comb begin
    pos_d    = pos_q;
    rounds_d = rounds_q;
    if (busy) begin
      rounds_d = rounds_q - 1'b1;
    end else if (pop) begin
      if (cmd_i.mode == ModeClear) begin
        pos_d = '0;
      end else if (end_blk) begin
        pos_d    = '0;
        rounds_d = round_count_i;
      end else begin
        pos_d = pos_inc[PosW-1:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    trit_d      = trit_q;
    if (pop && (cmd_i.mode == ModeSqueeze)) begin
      out_valid_d = 1'b1;
      trit_d      = sq_trit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rounds_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      rounds_q    <= rounds_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trit_q <= trit_d;
  end

endmodule

// ===== hdl/curl_p_sponge_hash_unit.sv =====
// Curl-P ternary sponge hash. Input beats enter a two-deep command queue at up to one per
// cycle while it is not full; the core executes one clear, absorb or squeeze command per
// cycle while no transform runs. A block ends after RATE_TRITS absorb/squeeze commands or
// at one flagged last; the transform then runs one full-width round per cycle until
// round_count rounds are done, and the core takes no command meanwhile.
// Squeeze results sit in an output register; the core holds a squeeze while it is stalled.
// The state resets to all zero trits at once, with no clearing pass.
// Depends on curlp_pkg, curlp_front, curlp_fifo, curlp_core and the defines header.
`include "curl_p_sponge_hash_unit_defines.svh"

module curl_p_sponge_hash_unit import curlp_pkg::*; #(
  parameter int unsigned STATE_TRITS = StateTritsDef,
  parameter int unsigned RATE_TRITS  = RateTritsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RoundW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic signed [1:0] trit_in_i,
  input  logic              last_of_block_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [1:0] trit_out_o
);

  logic [RoundW-1:0] round_count_q;
  logic              push, q_full, q_valid, pop;
  cmd_t              push_cmd, q_cmd;
  core_stat_t        stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= RoundCountRst;
    end else if (cfg_we_i) begin
      round_count_q <= cfg_wdata_i;
    end
  end

  curlp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .trit_in_i  (trit_in_i),
    .last_i     (last_of_block_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  curlp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  curlp_core #(
    .STATE_TRITS (STATE_TRITS),
    .RATE_TRITS  (RATE_TRITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .pop_o         (pop),
    .round_count_i (round_count_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .trit_out_o    (trit_out_o),
    .stat_o        (stat)
  );

  `CURLP_ASSERT_SAME(a_out_trit_ok, out_valid_o, trit_out_o != TritBad, "bad trit on output")
  `CURLP_ASSERT_SAME(a_no_pop_busy, stat.busy, !stat.pop, "command taken during transform")
  `CURLP_ASSERT_SAME(a_busy_after_pop, $rose(stat.busy), $past(stat.pop), "transform without command")

endmodule

// ===== test/tb_curl_p_sponge_hash_unit.sv =====
// Testbench for curl_p_sponge_hash_unit: directed, round-count, back-pressure and random beats,
// every squeezed trit checked against an in-bench sponge predictor.
// Depends on curlp_pkg and the curl_p_sponge_hash_unit RTL.
module tb_curl_p_sponge_hash_unit;
  import curlp_pkg::*;

  typedef logic signed [1:0] trit_t;

  localparam logic [1:0] ModeNone = 2'd3;
  localparam int QuietLimit = 20000;
  localparam int HoldOffCycles = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [RoundW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        mode_i;
  logic signed [1:0] trit_in_i;
  logic              last_of_block_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [1:0] trit_out_o;

  trit_t           sponge_model [StateTritsDef];
  trit_t           prev_round [StateTritsDef];
  logic [PosW-1:0] rate_pos;
  int              rounds_cfg;
  trit_t           squeeze_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_len;
  int quiet_cycles;
  int mismatches;
  int beats;
  int checked;
  int transforms;

  curl_p_sponge_hash_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .trit_in_i      (trit_in_i),
    .last_of_block_i(last_of_block_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trit_out_o     (trit_out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic trit_t curl_sbox(int idx);
    case (idx)
      0, 4, 9: return trit_t'(1);
      2, 5, 8: return trit_t'(-1);
      default: return trit_t'(0);
    endcase
  endfunction

  function automatic void clear_sponge();
    foreach (sponge_model[i]) sponge_model[i] = '0;
  endfunction

  function automatic logic [1:0] rand_trit();
    case ($urandom_range(0, 15))
      0:             return TritBad;
      1, 2, 3, 4, 5: return TritNeg;
      6, 7, 8, 9, 10: return TritZero;
      default:       return TritPos;
    endcase
  endfunction

  task automatic run_transform();
    int walk;
    int prev;
    walk = 0;
    for (int r = 0; r < rounds_cfg; r++) begin
      prev_round = sponge_model;
      for (int i = 0; i < StateTritsDef; i++) begin
        prev = walk;
        if (walk <= StateTritsDef / 2) walk += StateTritsDef / 2;
        else walk -= StateTritsDef - StateTritsDef / 2;
        if (walk >= StateTritsDef) walk -= StateTritsDef;
        sponge_model[i] = curl_sbox(int'(prev_round[prev]) + 4 * int'(prev_round[walk]) + 5);
      end
    end
    transforms++;
  endtask

  task automatic predict_beat(logic [1:0] m, logic [1:0] t, logic l);
    trit_t v;
    if (m == ModeClear) begin
      clear_sponge();
      rate_pos = '0;
      return;
    end
    if (m == ModeNone) return;
    if (m == ModeAbsorb) begin
      v = (t == TritPos) ? trit_t'(1) : (t == TritZero) ? trit_t'(0) : trit_t'(-1);
      if (rate_pos < StateTritsDef) sponge_model[rate_pos] = v;
    end else begin
      v = (rate_pos < StateTritsDef) ? sponge_model[rate_pos] : trit_t'(0);
      squeeze_q.push_back(v);
    end
    rate_pos = rate_pos + 1'b1;
    if (l || rate_pos >= RateTritsDef) begin
      run_transform();
      rate_pos = '0;
    end
  endtask

  task automatic push_beat(logic [1:0] m, logic [1:0] t, logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= m;
    trit_in_i       <= t;
    last_of_block_i <= l;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_beat(m, t, l);
    if (m != ModeNone) beats++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (squeeze_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_rounds(logic [RoundW-1:0] v);
    drain_results();
    repeat (3 * rounds_cfg + 20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    rounds_cfg = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_message(int n_abs, int n_sq);
    for (int i = 0; i < n_abs; i++)
      push_beat(ModeAbsorb, rand_trit(), (i == n_abs - 1) && (n_abs != RateTritsDef));
    for (int i = 0; i < n_sq; i++)
      push_beat(ModeSqueeze, rand_trit(), (i == n_sq - 1) && ($urandom_range(0, 1) == 1));
  endtask

  task automatic test_directed();
    push_beat(ModeClear, TritPos, 1'b1);
    push_beat(ModeAbsorb, TritPos, 1'b0);
    push_beat(ModeAbsorb, TritZero, 1'b0);
    push_beat(ModeAbsorb, TritNeg, 1'b0);
    push_beat(ModeAbsorb, TritBad, 1'b0);
    push_beat(ModeNone, TritNeg, 1'b1);
    push_beat(ModeSqueeze, TritZero, 1'b0);
    push_beat(ModeSqueeze, TritPos, 1'b1);
    repeat (3) push_beat(ModeSqueeze, TritNeg, 1'b0);
    push_beat(ModeAbsorb, TritNeg, 1'b1);
    push_beat(ModeClear, TritZero, 1'b0);
    push_beat(ModeSqueeze, TritZero, 1'b0);
  endtask

  task automatic test_round_counts();
    write_rounds(8'd0);
    push_beat(ModeClear, TritZero, 1'b0);
    run_message(5, 5);
    write_rounds(8'hFF);
    run_message(3, 4);
    write_rounds(8'd1);
    run_message(RateTritsDef, 3);
    write_rounds(8'd27);
    run_message(10, 6);
    write_rounds(RoundCountRst);
  endtask

  task automatic test_backpressure();
    hold_len = HoldOffCycles;
    run_message(4, 24);
    drain_results();
  endtask

  task automatic test_random(int target, int s_pct, int r_pct);
    int stop_at;
    int n_abs;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = beats + target;
    while (beats < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 3) != 0) push_beat(ModeClear, rand_trit(), 1'($urandom_range(0, 1)));
        n_abs = ($urandom_range(0, 11) == 0) ? RateTritsDef : $urandom_range(1, 30);
        run_message(n_abs, $urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    trit_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (squeeze_q.size() == 0) begin
        $display("%0t unexpected trit_out beat, expected none, got %0d", $time, trit_out_o);
        mismatches++;
      end else begin
        want = squeeze_q.pop_front();
        checked++;
        if (trit_out_o !== want) begin
          $display("%0t trit_out mismatch, expected %0d, got %0d", $time, want, trit_out_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t timeout, %0d results still expected", $time, squeeze_q.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    mode_i          = ModeClear;
    trit_in_i       = '0;
    last_of_block_i = 1'b0;
    quiet_cycles    = 0;
    hold_len        = 0;
    mismatches      = 0;
    beats           = 0;
    checked         = 0;
    transforms      = 0;
    send_idle_pct   = 10;
    recv_idle_pct   = 87;
    clear_sponge();
    rate_pos   = '0;
    rounds_cfg = RoundCountRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_round_counts();
    test_backpressure();
    test_random(160, 10, 87);
    test_random(160, 87, 10);
    test_random(160, 0, 0);

    drain_results();
    repeat (3 * rounds_cfg + 20) @(posedge clk_i);
    $display("covered %0d input beats, %0d transforms, %0d squeezed trits checked",
             beats, transforms, checked);
    $display("round counts 0, 1, 27, 81 and 255, long output hold-off, three idle mixes");
    if (mismatches == 0 && squeeze_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/curlp_pkg.sv
hdl/curlp_front.sv
hdl/curlp_fifo.sv
hdl/curlp_core.sv
hdl/curl_p_sponge_hash_unit.sv
test/tb_curl_p_sponge_hash_unit.sv
